// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the tachometer block. They expand to
// nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising clock edge out of reset.
`define HTS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising clock edge out of reset.
`define HTS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define HTS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define HTS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== sv/hts_pkg.sv =====
// ----------------------------------------------------------------------------
// Tachometer package
// Widths, constants, register indexes and the structs that join the
// configuration block, the controller and the datapath.
// ----------------------------------------------------------------------------
package hts_pkg;

    // Field widths.
    localparam int TIME_W     = 32;
    localparam int RPM_W      = 19;
    localparam int SPEED_W    = 23;
    localparam int MAG_W      = 7;
    localparam int DEB_W      = 20;
    localparam int JUMP_W     = 19;
    localparam int FACTOR_W   = 20;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    // Fixed-point rpm and the period divider.
    localparam int RPM_FRAC    = 4;
    localparam int QUOT_W      = 30;
    localparam int DENOM_W     = TIME_W + MAG_W;
    localparam int DIV_CNT_W   = $clog2(QUOT_W);
    localparam int PROD_W      = RPM_W + FACTOR_W;
    localparam int SPEED_SHIFT = 16;

    // Microseconds per minute with the rpm fraction bits applied.
    localparam logic [QUOT_W-1:0] RPM_NUMER = QUOT_W'(60000000 << RPM_FRAC);
    localparam logic [RPM_W-1:0]  RPM_SAT   = RPM_W'(480000);

    // Event kinds.
    localparam logic FUNC_EDGE  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAGNETS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_JUMP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STALL   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FACTOR  = 3'd6;

    // Register reset values.
    localparam logic [MAG_W-1:0]    RST_MAGNETS  = 7'd1;
    localparam logic [DEB_W-1:0]    RST_DEBOUNCE = 20'd2000;
    localparam logic [JUMP_W-1:0]   RST_JUMP     = 19'd12000;
    localparam logic [TIME_W-1:0]   RST_TIMEOUT  = 32'd5000000;
    localparam logic [RPM_W-1:0]    RST_STALL    = 19'd4800;
    localparam logic [FACTOR_W-1:0] RST_FACTOR   = 20'd5898;

    // Configuration register set.
    typedef struct packed {
        logic                enable;
        logic [MAG_W-1:0]    magnet_count;
        logic [DEB_W-1:0]    debounce_us;
        logic [JUMP_W-1:0]   jump_limit_rpm;
        logic [TIME_W-1:0]   stall_timeout_us;
        logic [RPM_W-1:0]    stall_rpm;
        logic [FACTOR_W-1:0] speed_factor;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic eval;
        logic mult;
        logic div_step;
        logic update;
        logic speed;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_div;
        logic div_last;
    } sts_t;

endpackage

// ===== sv/hall_tachometer_speed_unit.sv =====
// ----------------------------------------------------------------------------
// Hall tachometer speed unit
// Measures wheel rpm from timestamped hall edges and answers speed queries.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one event: func selects a hall
//   edge or a speed query, now_us is its microsecond timestamp. Every event
//   yields exactly one result on the output channel (out_valid/out_stall):
//   rpm_value, speed_value, edge_accepted and stalled.
//   An edge that passes debounce with a nonzero period while the block is
//   enabled runs the serial period divider, one quotient bit per cycle; such
//   an event goes through evaluation, the denominator multiply, the divider,
//   the rpm update, the speed multiply and the output load. All other events
//   go from evaluation to the speed multiply. The next event is accepted in
//   the cycle after the result is loaded into the output register.
//   The output register holds its result while out_stall is high; a new
//   event may be accepted meanwhile, and its result waits until the held
//   one is taken.
//   Reset loads the register defaults and clears the edge time and rpm.
//   The configuration port writes one register per cycle with cfg_write.
// ----------------------------------------------------------------------------
module hall_tachometer_speed_unit
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [hts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hts_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            func,
    input  logic [hts_pkg::TIME_W-1:0]      now_us,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [hts_pkg::RPM_W-1:0]       rpm_value,
    output logic [hts_pkg::SPEED_W-1:0]     speed_value,
    output logic                            edge_accepted,
    output logic                            stalled
);
    import hts_pkg::*;

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;
    logic clear_state;

    // Configuration registers.
    hts_regs u_regs
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cfg         (cfg),
        .clear_state (clear_state)
    );

    // Sequencer.
    hts_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Datapath.
    hts_dp u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .clear_state   (clear_state),
        .cmd           (cmd),
        .sts           (sts),
        .func          (func),
        .now_us        (now_us),
        .rpm_value     (rpm_value),
        .speed_value   (speed_value),
        .edge_accepted (edge_accepted),
        .stalled       (stalled)
    );

endmodule

// ===== sv/hts_regs.sv =====
// ----------------------------------------------------------------------------
// Tachometer configuration registers
// Holds the seven write-only settings and flags a write that disables the
// block, which clears the measurement state.
// ----------------------------------------------------------------------------
module hts_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [hts_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hts_pkg::CFG_DATA_W-1:0]  cfg_data,
    output hts_pkg::cfg_t                   cfg,
    output logic                            clear_state
);
    import hts_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode a write; each value is truncated to its register width.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_ENABLE:   cfg_next.enable           = cfg_data[0];
                REG_MAGNETS:  cfg_next.magnet_count     = cfg_data[MAG_W-1:0];
                REG_DEBOUNCE: cfg_next.debounce_us      = cfg_data[DEB_W-1:0];
                REG_JUMP:     cfg_next.jump_limit_rpm   = cfg_data[JUMP_W-1:0];
                REG_TIMEOUT:  cfg_next.stall_timeout_us = cfg_data[TIME_W-1:0];
                REG_STALL:    cfg_next.stall_rpm        = cfg_data[RPM_W-1:0];
                REG_FACTOR:   cfg_next.speed_factor     = cfg_data[FACTOR_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    // Register storage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable           <= 1'b1;
            cfg_reg.magnet_count     <= RST_MAGNETS;
            cfg_reg.debounce_us      <= RST_DEBOUNCE;
            cfg_reg.jump_limit_rpm   <= RST_JUMP;
            cfg_reg.stall_timeout_us <= RST_TIMEOUT;
            cfg_reg.stall_rpm        <= RST_STALL;
            cfg_reg.speed_factor     <= RST_FACTOR;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg         = cfg_reg;
    assign clear_state = cfg_write && (cfg_index == REG_ENABLE) && !cfg_data[0];

endmodule

// ===== sv/hts_ctrl.sv =====
// ----------------------------------------------------------------------------
// Tachometer controller
// State machine that sequences one request through evaluation, the period
// divider and rpm update when needed, the speed multiply and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hts_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  logic           out_stall,
    input  hts_pkg::sts_t  sts,
    output hts_pkg::cmd_t  cmd
);
    import hts_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EVAL   = 3'd1;
    localparam logic [2:0] S_MULT   = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_UPDATE = 3'd4;
    localparam logic [2:0] S_SPEED  = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;
    logic       accept;

    // A new request is taken only when the sequencer is free.
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    // The output register can take a result when empty or being drained.
    assign out_free = !out_valid_reg || !out_stall;

    // Commands follow from the state; capture and load_out also depend on the handshakes.
    always_comb
    begin
        cmd          = '0;
        cmd.capture  = accept;
        cmd.eval     = (state_reg == S_EVAL);
        cmd.mult     = (state_reg == S_MULT);
        cmd.div_step = (state_reg == S_DIV);
        cmd.update   = (state_reg == S_UPDATE);
        cmd.speed    = (state_reg == S_SPEED);
        cmd.load_out = (state_reg == S_DONE) && out_free;
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = sts.need_div ? S_MULT : S_SPEED;
            end
            S_MULT:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                state_next = S_SPEED;
            end
            S_SPEED:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid flag: set on load, cleared when the result is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // A held result is never overwritten, and an accepted request starts evaluation.
    `HTS_ASSERT_IMP(a_no_overwrite, clk, rst_n, cmd.load_out, !(out_valid_reg && out_stall), "result overwritten while stalled")
    `HTS_ASSERT_NXT(a_accept_eval, clk, rst_n, accept, state_reg == S_EVAL, "accepted request did not start evaluation")
    `HTS_ASSERT_IMP(a_div_only_long, clk, rst_n, (state_reg == S_EVAL) && !sts.need_div, state_next == S_SPEED, "short path entered the divider")

endmodule

// ===== sv/hts_dp.sv =====
// ----------------------------------------------------------------------------
// Tachometer datapath
// Edge timing, debounce and stall tests, the serial period divider, the rpm
// jump filter, the speed multiplier and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hts_dp
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  hts_pkg::cfg_t                 cfg,
    input  logic                          clear_state,
    input  hts_pkg::cmd_t                 cmd,
    output hts_pkg::sts_t                 sts,
    input  logic                          func,
    input  logic [hts_pkg::TIME_W-1:0]    now_us,
    output logic [hts_pkg::RPM_W-1:0]     rpm_value,
    output logic [hts_pkg::SPEED_W-1:0]   speed_value,
    output logic                          edge_accepted,
    output logic                          stalled
);
    import hts_pkg::*;

    logic                  func_reg;
    logic [TIME_W-1:0]     now_reg;
    logic [TIME_W-1:0]     last_edge_reg;
    logic [TIME_W-1:0]     last_edge_next;
    logic [RPM_W-1:0]      rpm_reg;
    logic [RPM_W-1:0]      rpm_next;
    logic                  acc_reg;
    logic                  acc_next;
    logic                  stall_reg;
    logic                  stall_next;
    logic [TIME_W-1:0]     period_reg;
    logic [DENOM_W-1:0]    denom_reg;
    logic [DENOM_W-1:0]    rem_reg;
    logic [QUOT_W-1:0]     quot_reg;
    logic [DIV_CNT_W-1:0]  div_cnt_reg;
    logic [PROD_W-1:0]     prod_reg;

    logic [TIME_W-1:0]     elapsed;
    logic                  debounce_ok;
    logic                  stall_hit;
    logic [MAG_W-1:0]      mags;
    logic [DENOM_W:0]      trial;
    logic [DENOM_W:0]      trial_diff;
    logic                  fits;
    logic [QUOT_W-1:0]     old_wide;
    logic [QUOT_W-1:0]     rpm_diff;
    logic                  jump_reject;
    logic [RPM_W-1:0]      quot_sat;

    // Time since the last accepted edge, modulo the timestamp width.
    assign elapsed     = now_reg - last_edge_reg;
    assign debounce_ok = (elapsed >= TIME_W'(cfg.debounce_us));
    assign stall_hit   = (elapsed > cfg.stall_timeout_us) && (rpm_reg < cfg.stall_rpm);

    // An accepted edge with a nonzero period needs a new rpm from the divider.
    assign sts.need_div = cfg.enable && (func_reg == FUNC_EDGE) && debounce_ok
                          && (elapsed != '0);
    assign sts.div_last = (div_cnt_reg == '0);

    // A magnet count of zero counts as one.
    assign mags = (cfg.magnet_count == '0) ? MAG_W'(1) : cfg.magnet_count;

    // One restoring division step: bring down the next numerator bit.
    assign trial      = {rem_reg, RPM_NUMER[div_cnt_reg]};
    assign trial_diff = trial - {1'b0, denom_reg};
    assign fits       = (trial >= {1'b0, denom_reg});

    // Jump filter compares the unsaturated quotient with the old rpm.
    assign old_wide    = QUOT_W'(rpm_reg);
    assign rpm_diff    = (quot_reg > old_wide) ? (quot_reg - old_wide) : (old_wide - quot_reg);
    assign jump_reject = (rpm_reg != '0) && (rpm_diff > QUOT_W'(cfg.jump_limit_rpm));
    assign quot_sat    = (quot_reg > QUOT_W'(RPM_SAT)) ? RPM_SAT : quot_reg[RPM_W-1:0];

    // Measurement state and result flags.
    always_comb
    begin
        last_edge_next = last_edge_reg;
        rpm_next       = rpm_reg;
        acc_next       = acc_reg;
        stall_next     = stall_reg;
        if (cmd.capture)
        begin
            acc_next   = 1'b0;
            stall_next = 1'b0;
        end
        if (clear_state)
        begin
            last_edge_next = '0;
            rpm_next       = '0;
        end
        else if (cmd.eval)
        begin
            if (!cfg.enable)
            begin
                last_edge_next = '0;
                rpm_next       = '0;
            end
            else if (func_reg == FUNC_EDGE)
            begin
                if (debounce_ok)
                begin
                    last_edge_next = now_reg;
                    acc_next       = 1'b1;
                end
            end
            else if (stall_hit)
            begin
                rpm_next   = '0;
                stall_next = 1'b1;
            end
        end
        else if (cmd.update)
        begin
            if (!jump_reject)
            begin
                rpm_next = quot_sat;
            end
        end
    end

    // State and flag registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_edge_reg <= '0;
            rpm_reg       <= '0;
            acc_reg       <= 1'b0;
            stall_reg     <= 1'b0;
        end
        else
        begin
            last_edge_reg <= last_edge_next;
            rpm_reg       <= rpm_next;
            acc_reg       <= acc_next;
            stall_reg     <= stall_next;
        end
    end

    // Request capture, divider and speed multiplier.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= func;
            now_reg  <= now_us;
        end
        if (cmd.eval)
        begin
            period_reg <= elapsed;
        end
        if (cmd.mult)
        begin
            denom_reg   <= DENOM_W'(period_reg) * DENOM_W'(mags);
            rem_reg     <= '0;
            div_cnt_reg <= DIV_CNT_W'(QUOT_W - 1);
        end
        if (cmd.div_step)
        begin
            rem_reg     <= fits ? trial_diff[DENOM_W-1:0] : trial[DENOM_W-1:0];
            quot_reg    <= {quot_reg[QUOT_W-2:0], fits};
            div_cnt_reg <= div_cnt_reg - DIV_CNT_W'(1);
        end
        if (cmd.speed)
        begin
            prod_reg <= PROD_W'(rpm_reg) * PROD_W'(cfg.speed_factor);
        end
    end

    // Output register. The shifted product fills the speed field exactly,
    // so no upper bits are dropped.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            rpm_value     <= rpm_reg;
            speed_value   <= prod_reg[PROD_W-1:SPEED_SHIFT];
            edge_accepted <= acc_reg;
            stalled       <= stall_reg;
        end
    end

    // The rpm stays saturated, and a stalled result always carries zero rpm.
    `HTS_ASSERT_IMP(a_rpm_sat, clk, rst_n, 1'b1, rpm_reg <= RPM_SAT, "rpm above saturation")
    `HTS_ASSERT_IMP(a_flags_excl, clk, rst_n, acc_reg, !stall_reg, "edge and stall flags both set")
    `HTS_ASSERT_IMP(a_stall_zero, clk, rst_n, stall_reg, rpm_reg == '0, "stall left rpm nonzero")

endmodule
